// ===== sv/dhse_pkg.sv =====
// Shared constants, types and hash helpers for the double hash set engine.
`timescale 1ns / 1ps
package dhse_pkg;

    localparam int SLOT_COUNT    = 64;
    localparam int SLOT_W        = $clog2(SLOT_COUNT);
    localparam int MAX_KEY_BYTES = 8;
    localparam int KEY_W         = 64;
    localparam int HASH_W        = 64;
    localparam int LEN_W         = 4;
    localparam int CAP_W         = 7;
    localparam int PCT_W         = 7;
    localparam int STATUS_W      = 3;
    localparam int LIVE_W        = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 7;
    localparam int MARK_W        = 2;
    localparam int LOAD_W        = 14;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'd2166136261;

    localparam logic [CAP_W-1:0]  CAP_RESET   = 7'd31;
    localparam logic [PCT_W-1:0]  LIMIT_RESET = 7'd75;
    localparam logic [LOAD_W-1:0] PCT_SCALE   = 14'd100;
    localparam logic [CAP_W-1:0]  CAP_MIN     = 7'd2;
    localparam logic [CAP_W-1:0]  CAP_MAX     = CAP_W'(SLOT_COUNT);
    localparam logic [LIVE_W-1:0] LIVE_MAX    = 7'd127;

    localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
    localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT = 2'd1;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  len;
    } slot_rec_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [MARK_W-1:0] mark;
        logic              rec_en;
        slot_rec_t         rec;
    } mem_wr_t;

    // multiply by the FNV prime 2^24 + 403, wrapping at 64 bits
    function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] h);
        return (h << 24) + (h << 8) + (h << 7) + (h << 4) + (h << 1) + h;
    endfunction

endpackage

// ===== sv/dhse_if.sv =====
// Channel interfaces: request, response and configuration write.
`timescale 1ns / 1ps
interface dhse_req_if;
    import dhse_pkg::*;
    logic             valid;
    logic             ready;
    logic             operation;
    logic [KEY_W-1:0] key_bytes;
    logic [LEN_W-1:0] key_length;
    modport source(output valid, output operation, output key_bytes, output key_length,
                   input ready);
    modport sink(input valid, input operation, input key_bytes, input key_length,
                 output ready);
endinterface

interface dhse_rsp_if;
    import dhse_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [LIVE_W-1:0]   live_entries;
    modport source(output valid, output status, output slot_index, output live_entries,
                   input ready);
    modport sink(input valid, input status, input slot_index, input live_entries,
                 output ready);
endinterface

interface dhse_cfg_if;
    import dhse_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== sv/dhse_hash.sv =====
// Byte-serial FNV-1a and FNV-1 hash unit, one key byte per cycle.
`timescale 1ns / 1ps
module dhse_hash
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [dhse_pkg::KEY_W-1:0]  key,
    input  logic [dhse_pkg::LEN_W-1:0]  len,
    output logic                   busy,
    output logic [dhse_pkg::HASH_W-1:0] ha,
    output logic [dhse_pkg::HASH_W-1:0] hb
);
    import dhse_pkg::*;

    logic              busy_reg;
    logic [LEN_W-1:0]  cnt_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [HASH_W-1:0] ha_reg;
    logic [HASH_W-1:0] hb_reg;
    logic [HASH_W-1:0] byte_ext;
    logic              last;

    assign byte_ext = HASH_W'(key_reg[7:0]);
    assign last     = (cnt_reg == len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ha_reg  <= FNV_BASIS;
            hb_reg  <= FNV_BASIS;
            key_reg <= key;
            len_reg <= len;
        end
        else if (busy_reg && !last)
        begin
            ha_reg  <= fnv_mul(ha_reg ^ byte_ext);
            hb_reg  <= fnv_mul(hb_reg) ^ byte_ext;
            key_reg <= key_reg >> 8;
        end
    end

    assign busy = busy_reg;
    assign ha   = ha_reg;
    assign hb   = hb_reg;

endmodule

// ===== sv/dhse_mod.sv =====
// Bit-serial reduction of home hash, step and 2^64 modulo the capacity.
`timescale 1ns / 1ps
module dhse_mod
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dhse_pkg::CAP_W-1:0]  cap,
    input  logic [dhse_pkg::HASH_W-1:0] ha,
    input  logic [dhse_pkg::HASH_W-1:0] hb1,
    output logic                       busy,
    output logic [dhse_pkg::CAP_W-1:0]  ha_mod,
    output logic [dhse_pkg::CAP_W-1:0]  hb_mod,
    output logic [dhse_pkg::CAP_W-1:0]  wrap_mod
);
    import dhse_pkg::*;

    localparam int CNT_W = $clog2(HASH_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(HASH_W);

    function automatic logic [CAP_W-1:0] rem_step(input logic [CAP_W-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [CAP_W-1:0] c);
        logic [CAP_W:0] r2;
        r2 = {rem, bit_in};
        if (r2 >= {1'b0, c})
        begin
            r2 = r2 - {1'b0, c};
        end
        return r2[CAP_W-1:0];
    endfunction

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [HASH_W-1:0] sa_reg;
    logic [HASH_W-1:0] sb_reg;
    logic [CAP_W-1:0]  ra_reg;
    logic [CAP_W-1:0]  rb_reg;
    logic [CAP_W-1:0]  rc_reg;
    logic              first;
    logic              bit_a;
    logic              bit_b;

    assign first = (cnt_reg == '0);
    assign bit_a = first ? 1'b0 : sa_reg[HASH_W-1];
    assign bit_b = first ? 1'b0 : sb_reg[HASH_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sa_reg <= ha;
            sb_reg <= hb1;
            ra_reg <= '0;
            rb_reg <= '0;
            rc_reg <= '0;
        end
        else if (busy_reg)
        begin
            ra_reg <= rem_step(ra_reg, bit_a, cap);
            rb_reg <= rem_step(rb_reg, bit_b, cap);
            rc_reg <= rem_step(rc_reg, first, cap);
            if (!first)
            begin
                sa_reg <= sa_reg << 1;
                sb_reg <= sb_reg << 1;
            end
        end
    end

    assign busy     = busy_reg;
    assign ha_mod   = ra_reg;
    assign hb_mod   = rb_reg;
    assign wrap_mod = rc_reg;

endmodule

// ===== sv/dhse_mem.sv =====
// Slot store: marks with per-slot valid bits, and key records.
`timescale 1ns / 1ps
module dhse_mem
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [dhse_pkg::SLOT_W-1:0]  rd_addr,
    input  dhse_pkg::mem_wr_t            wr,
    output logic [dhse_pkg::MARK_W-1:0]  rd_mark,
    output dhse_pkg::slot_rec_t          rd_rec
);
    import dhse_pkg::*;

    logic [SLOT_COUNT-1:0] valid_reg;
    logic [MARK_W-1:0]     mark_mem [SLOT_COUNT];
    slot_rec_t             rec_mem  [SLOT_COUNT];
    logic [MARK_W-1:0]     mark_q;
    logic                  vld_q;
    slot_rec_t             rec_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mark_mem[wr.addr] <= wr.mark;
        end
        if (wr.en && wr.rec_en)
        begin
            rec_mem[wr.addr] <= wr.rec;
        end
        if (rd_en)
        begin
            mark_q <= mark_mem[rd_addr];
            rec_q  <= rec_mem[rd_addr];
            vld_q  <= valid_reg[rd_addr];
        end
    end

    assign rd_mark = vld_q ? mark_q : MARK_EMPTY;
    assign rd_rec  = rec_q;

endmodule

// ===== sv/double_hash_set_engine.sv =====
// Top level: sequencer, probe arithmetic, live count and channel registers.
// Sequence: hash the key, reduce hash, step and wrap modulo the capacity, check the load limit
// on an insert, then read and evaluate probes in turn, write the slot if needed, register the response.
// Requests: one item at a time; request.ready is high only while idle.
// Reset: all slots read empty at once through per-slot valid bits, no sweep;
// capacity 31, load limit 75, live count zero.
`timescale 1ns / 1ps
module double_hash_set_engine
(
    input  logic       clk,
    input  logic       rst_n,
    dhse_req_if.sink   request,
    dhse_rsp_if.source response,
    dhse_cfg_if.sink   cfg
);
    import dhse_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_HASH  = 8'b0000_0010,
        S_MOD   = 8'b0000_0100,
        S_LOAD  = 8'b0000_1000,
        S_READ  = 8'b0001_0000,
        S_EVAL  = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [CAP_W-1:0]    cap_reg;
    logic [PCT_W-1:0]    limit_reg;
    logic [LIVE_W-1:0]   live_reg;
    logic                op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [HASH_W-1:0]   v_reg;
    logic [SLOT_W-1:0]   pos_reg;
    logic [CAP_W-1:0]    hbm_reg;
    logic [CAP_W-1:0]    wrap_reg;
    logic [CAP_W-1:0]    cnt_reg;
    logic                have_tomb_reg;
    logic [SLOT_W-1:0]   tomb_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [LIVE_W-1:0]   out_live_reg;

    logic [CAP_W-1:0]    cap_eff;
    logic [LEN_W-1:0]    len_eff;
    logic [KEY_W-1:0]    key_masked;
    logic                accept;
    logic                hash_busy;
    logic [HASH_W-1:0]   ha;
    logic [HASH_W-1:0]   hb;
    logic [HASH_W-1:0]   hb1;
    logic                mod_start;
    logic                mod_busy;
    logic [CAP_W-1:0]    ha_mod;
    logic [CAP_W-1:0]    hb_mod;
    logic [CAP_W-1:0]    wrap_mod;
    logic                load_full;
    logic [MARK_W-1:0]   rd_mark;
    slot_rec_t           rd_rec;
    mem_wr_t             mem_wr;
    logic                hit;
    logic                tomb_new;
    logic                tomb_have_n;
    logic [SLOT_W-1:0]   tomb_slot_n;
    logic                last_probe;
    logic [HASH_W:0]     v_sum;
    logic [CAP_W:0]      t0;
    logic [CAP_W:0]      t1;
    logic [CAP_W:0]      t2;
    logic                out_free;

    always_comb
    begin
        cap_eff = cap_reg;
        if (cap_reg < CAP_MIN)
        begin
            cap_eff = CAP_MIN;
        end
        else if (cap_reg > CAP_MAX)
        begin
            cap_eff = CAP_MAX;
        end
    end

    assign len_eff = (request.key_length > LEN_W'(MAX_KEY_BYTES)) ?
                     LEN_W'(MAX_KEY_BYTES) : request.key_length;

    always_comb
    begin
        for (int i = 0; i < MAX_KEY_BYTES; i++)
        begin
            key_masked[8*i +: 8] = (LEN_W'(i) < len_eff) ? request.key_bytes[8*i +: 8] : 8'h00;
        end
    end

    assign accept        = request.valid && request.ready;
    assign request.ready = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;

    dhse_hash u_hash
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .key   (key_masked),
        .len   (len_eff),
        .busy  (hash_busy),
        .ha    (ha),
        .hb    (hb)
    );

    assign hb1       = hb + 1'b1;
    assign mod_start = (state_reg == S_HASH) && !hash_busy;

    dhse_mod u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .cap      (cap_eff),
        .ha       (ha),
        .hb1      (hb1),
        .busy     (mod_busy),
        .ha_mod   (ha_mod),
        .hb_mod   (hb_mod),
        .wrap_mod (wrap_mod)
    );

    always_comb
    begin
        mem_wr.en     = (state_reg == S_WRITE);
        mem_wr.addr   = res_slot_reg;
        mem_wr.mark   = op_reg ? MARK_TOMB : MARK_LIVE;
        mem_wr.rec_en = !op_reg;
        mem_wr.rec    = '{hash: ha, key: key_reg, len: len_reg};
    end

    dhse_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (state_reg == S_READ),
        .rd_addr (pos_reg),
        .wr      (mem_wr),
        .rd_mark (rd_mark),
        .rd_rec  (rd_rec)
    );

    assign load_full = (LOAD_W'(live_reg) * PCT_SCALE) >=
                       (LOAD_W'(limit_reg) * LOAD_W'(cap_eff));

    assign hit = (rd_mark == MARK_LIVE) && (rd_rec.hash == ha) &&
                 (rd_rec.len == len_reg) && (rd_rec.key == key_reg);
    assign tomb_new    = (rd_mark == MARK_TOMB) && !have_tomb_reg;
    assign tomb_have_n = have_tomb_reg || tomb_new;
    assign tomb_slot_n = have_tomb_reg ? tomb_reg : pos_reg;
    assign last_probe  = ({1'b0, cnt_reg} + 1'b1) == {1'b0, cap_eff};

    // next probe slot, folding the 2^64 wrap back in modulo the capacity
    assign v_sum = {1'b0, v_reg} + {1'b0, hb1};
    assign t0    = (CAP_W+1)'(pos_reg) + {1'b0, hbm_reg} +
                   (v_sum[HASH_W] ? {1'b0, cap_eff - wrap_reg} : '0);
    assign t1    = (t0 >= {1'b0, cap_eff}) ? t0 - {1'b0, cap_eff} : t0;
    assign t2    = (t1 >= {1'b0, cap_eff}) ? t1 - {1'b0, cap_eff} : t1;

    assign out_free = !out_valid_reg || response.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (!hash_busy)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (!mod_busy)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = (!op_reg && load_full) ? S_FIN : S_READ;
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (rd_mark == MARK_EMPTY)
                begin
                    state_next = op_reg ? S_FIN : S_WRITE;
                end
                else if (hit)
                begin
                    state_next = op_reg ? S_WRITE : S_FIN;
                end
                else if (last_probe)
                begin
                    state_next = (tomb_have_n && !op_reg) ? S_WRITE : S_FIN;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_WRITE:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            limit_reg     <= LIMIT_RESET;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_CAPACITY:   cap_reg   <= cfg.data;
                    CFG_LOAD_LIMIT: limit_reg <= cfg.data;
                    default:        ;
                endcase
            end
            if (state_reg == S_WRITE)
            begin
                if (!op_reg && live_reg != LIVE_MAX)
                begin
                    live_reg <= live_reg + 1'b1;
                end
                else if (op_reg && live_reg != '0)
                begin
                    live_reg <= live_reg - 1'b1;
                end
            end
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= request.operation;
            key_reg <= key_masked;
            len_reg <= len_eff;
        end
        if (state_reg == S_MOD && !mod_busy)
        begin
            v_reg         <= ha;
            pos_reg       <= ha_mod[SLOT_W-1:0];
            hbm_reg       <= hb_mod;
            wrap_reg      <= wrap_mod;
            cnt_reg       <= '0;
            have_tomb_reg <= 1'b0;
        end
        if (state_reg == S_LOAD)
        begin
            res_status_reg <= ST_FULL;
            res_slot_reg   <= '0;
        end
        if (state_reg == S_EVAL)
        begin
            if (rd_mark == MARK_EMPTY)
            begin
                res_status_reg <= op_reg ? ST_NOTFOUND : ST_INSERTED;
                res_slot_reg   <= op_reg ? '0 : tomb_slot_n;
            end
            else if (hit)
            begin
                res_status_reg <= op_reg ? ST_REMOVED : ST_PRESENT;
                res_slot_reg   <= pos_reg;
            end
            else if (last_probe)
            begin
                if (op_reg)
                begin
                    res_status_reg <= ST_NOTFOUND;
                    res_slot_reg   <= '0;
                end
                else if (tomb_have_n)
                begin
                    res_status_reg <= ST_INSERTED;
                    res_slot_reg   <= tomb_slot_n;
                end
                else
                begin
                    res_status_reg <= ST_FULL;
                    res_slot_reg   <= '0;
                end
            end
            else
            begin
                v_reg   <= v_sum[HASH_W-1:0];
                pos_reg <= t2[SLOT_W-1:0];
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (tomb_new)
            begin
                have_tomb_reg <= 1'b1;
                tomb_reg      <= pos_reg;
            end
        end
        if (state_reg == S_FIN && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_live_reg   <= live_reg;
        end
    end

    assign response.valid        = out_valid_reg;
    assign response.status       = out_status_reg;
    assign response.slot_index   = out_slot_reg;
    assign response.live_entries = out_live_reg;

endmodule

// ===== sv/dhse_checker.sv =====
// Port-level checker for the double hash set engine, bound to the top level.
`timescale 1ns / 1ps
module dhse_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [dhse_pkg::STATUS_W-1:0] rsp_status,
    input logic [dhse_pkg::SLOT_W-1:0]   rsp_slot_index,
    input logic [dhse_pkg::LIVE_W-1:0]   rsp_live_entries
);
    import dhse_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
        $stable(rsp_slot_index) && $stable(rsp_live_entries))
        else $error("response beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in work");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("result appeared one cycle after accept");

    a_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_NOTFOUND) |->
        rsp_slot_index == '0)
        else $error("full or not-found result carries a nonzero slot");

endmodule

bind double_hash_set_engine dhse_checker u_dhse_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (request.valid),
    .req_ready        (request.ready),
    .rsp_valid        (response.valid),
    .rsp_ready        (response.ready),
    .rsp_status       (response.status),
    .rsp_slot_index   (response.slot_index),
    .rsp_live_entries (response.live_entries)
);

// ===== dv/dhse_tb_if.sv =====
// Testbench package: row type of the directed stimulus table.
`timescale 1ns / 1ps
package dhse_tb_pkg;
    import dhse_pkg::*;

    typedef struct {
        logic             operation;
        logic [KEY_W-1:0] key_bytes;
        logic [LEN_W-1:0] key_length;
        logic             typed;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [LIVE_W-1:0]   live_entries;
    } probe_row_t;
endpackage

// ===== dv/double_hash_set_engine_tb.sv =====
// Testbench for the double hash set engine: directed table, random ops, set predictor.
`timescale 1ns / 1ps
module double_hash_set_engine_tb;
    import dhse_pkg::*;
    import dhse_tb_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [LIVE_W-1:0]   live_entries;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #4 clk = ~clk;

    dhse_req_if request();
    dhse_rsp_if response();
    dhse_cfg_if cfg();

    double_hash_set_engine DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .request(request),
        .response(response),
        .cfg(cfg)
    );

    logic [MARK_W-1:0] set_mark [SLOT_COUNT];
    logic [HASH_W-1:0] set_hash [SLOT_COUNT];
    logic [KEY_W-1:0]  set_key [SLOT_COUNT];
    logic [LEN_W-1:0]  set_len [SLOT_COUNT];
    int unsigned       set_live;
    logic [CAP_W-1:0]  set_capacity;
    logic [PCT_W-1:0]  set_limit;

    verdict_t    pending_verdicts[$];
    int          mismatch_count = 0;
    logic [KEY_W-1:0] key_pool[$];
    logic [LEN_W-1:0] len_pool[$];

    function automatic int unsigned used_slots();
        if (set_capacity < CAP_MIN)
        begin
            return CAP_MIN;
        end
        if (set_capacity > CAP_MAX)
        begin
            return CAP_MAX;
        end
        return set_capacity;
    endfunction

    function automatic logic [HASH_W-1:0] fnv_prime_mul(input logic [HASH_W-1:0] h);
        return h * 64'd16777619;
    endfunction

    function automatic verdict_t apply_op(input logic op, input logic [KEY_W-1:0] raw,
                                          input logic [LEN_W-1:0] raw_len);
        verdict_t v;
        int unsigned len;
        int unsigned cap;
        logic [KEY_W-1:0] key;
        logic [HASH_W-1:0] ha;
        logic [HASH_W-1:0] hb;
        logic [HASH_W-1:0] pos;
        int unsigned s;
        int found;
        int unsigned chosen;
        bit have_tomb;
        int unsigned tomb;
        len = (raw_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : raw_len;
        key = (len >= 8) ? raw : (raw & ((64'd1 << (8 * len)) - 64'd1));
        ha = FNV_BASIS;
        hb = FNV_BASIS;
        for (int i = 0; i < len; i++)
        begin
            ha = fnv_prime_mul(ha ^ ((key >> (8 * i)) & 64'hFF));
            hb = fnv_prime_mul(hb) ^ ((key >> (8 * i)) & 64'hFF);
        end
        hb = hb + 64'd1;
        cap = used_slots();
        v.slot_index = '0;
        if (op == 1'b0 && (set_live * 100) / cap >= set_limit)
        begin
            v.status = ST_FULL;
            v.live_entries = set_live[LIVE_W-1:0];
            return v;
        end
        found = -1;
        chosen = 0;
        have_tomb = 1'b0;
        tomb = 0;
        for (int unsigned i = 0; i < cap && found < 0; i++)
        begin
            pos = ha + 64'(i) * hb;
            s = 32'(pos % 64'(cap));
            if (set_mark[s] == MARK_EMPTY)
            begin
                found = 0;
                chosen = have_tomb ? tomb : s;
            end
            else if (set_mark[s] == MARK_LIVE && set_hash[s] == ha &&
                     set_len[s] == len && set_key[s] == key)
            begin
                found = 1;
                chosen = s;
            end
            else if (set_mark[s] == MARK_TOMB && !have_tomb)
            begin
                have_tomb = 1'b1;
                tomb = s;
            end
        end
        if (found < 0 && have_tomb)
        begin
            found = 0;
            chosen = tomb;
        end
        if (op == 1'b0)
        begin
            if (found == 1)
            begin
                v.status = ST_PRESENT;
                v.slot_index = SLOT_W'(chosen);
            end
            else if (found == 0)
            begin
                set_mark[chosen] = MARK_LIVE;
                set_hash[chosen] = ha;
                set_key[chosen] = key;
                set_len[chosen] = LEN_W'(len);
                if (set_live < 127)
                begin
                    set_live++;
                end
                v.status = ST_INSERTED;
                v.slot_index = SLOT_W'(chosen);
            end
            else
            begin
                v.status = ST_FULL;
            end
        end
        else if (found == 1)
        begin
            set_mark[chosen] = MARK_TOMB;
            set_hash[chosen] = '0;
            if (set_live > 0)
            begin
                set_live--;
            end
            v.status = ST_REMOVED;
            v.slot_index = SLOT_W'(chosen);
        end
        else
        begin
            v.status = ST_NOTFOUND;
        end
        v.live_entries = set_live[LIVE_W-1:0];
        return v;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == CFG_CAPACITY)
        begin
            set_capacity = value;
        end
        else
        begin
            set_limit = value;
        end
        @(posedge clk);
    endtask

    task automatic drain_results();
        request.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (220) @(posedge clk);
    endtask

    task automatic send_op(input logic op, input logic [KEY_W-1:0] key,
                           input logic [LEN_W-1:0] len, input bit typed,
                           input verdict_t typed_v);
        verdict_t v;
        int unsigned gap;
        gap = $urandom_range(0, 14);
        if (gap != 0)
        begin
            request.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request.valid <= 1'b1;
        request.operation <= op;
        request.key_bytes <= key;
        request.key_length <= len;
        do
        begin
            @(posedge clk);
        end
        while (!request.ready);
        v = apply_op(op, key, len);
        if (typed && v != typed_v)
        begin
            $display("%0t table row disagrees: table %0d/%0d/%0d computed %0d/%0d/%0d",
                     $time, typed_v.status, typed_v.slot_index, typed_v.live_entries,
                     v.status, v.slot_index, v.live_entries);
            mismatch_count++;
        end
        pending_verdicts.push_back(v);
    endtask

    always @(posedge clk)
    begin
        verdict_t e;
        if (rst_n && response.valid && response.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t unexpected beat: actual %0d/%0d/%0d", $time,
                         response.status, response.slot_index, response.live_entries);
                mismatch_count++;
            end
            else
            begin
                e = pending_verdicts.pop_front();
                if (e.status !== response.status || e.slot_index !== response.slot_index ||
                    e.live_entries !== response.live_entries)
                begin
                    $display("%0t mismatch: expected %0d/%0d/%0d actual %0d/%0d/%0d",
                             $time, e.status, e.slot_index, e.live_entries,
                             response.status, response.slot_index, response.live_entries);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int unsigned gap;
        response.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                response.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                gap = $urandom_range(0, 14);
                if (gap != 0)
                begin
                    response.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                response.ready <= 1'b1;
                do
                begin
                    @(posedge clk);
                end
                while (!response.valid);
            end
        end
    end

    task automatic random_phase(input int count, input int unsigned key_span);
        logic op;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        verdict_t none;
        int pick;
        none = '{default: '0};
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 9);
            op = ($urandom_range(0, 2) == 0);
            if (pick < 7 && key_pool.size() != 0)
            begin
                pick = $urandom_range(0, key_pool.size() - 1);
                key = key_pool[pick];
                len = len_pool[pick];
            end
            else
            begin
                key = {$urandom, $urandom};
                if ($urandom_range(0, 1))
                begin
                    key = key % key_span;
                end
                len = $urandom_range(0, 15);
                if (key_pool.size() < 24)
                begin
                    key_pool.push_back(key);
                    len_pool.push_back(len);
                end
                else
                begin
                    pick = $urandom_range(0, 23);
                    key_pool[pick] = key;
                    len_pool[pick] = len;
                end
            end
            send_op(op, key, len, 1'b0, none);
        end
    endtask

    probe_row_t directed_rows[] = '{
        '{1'b1, 64'h0, 4'd0, 1'b1, ST_NOTFOUND, 6'd0, 7'd0},
        '{1'b0, 64'h0, 4'd0, 1'b0, ST_INSERTED, 6'd0, 7'd1},
        '{1'b0, 64'hFFFF_FFFF_FFFF_FF00, 4'd0, 1'b0, ST_PRESENT, 6'd0, 7'd1},
        '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, ST_INSERTED, 6'd0, 7'd2},
        '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, ST_PRESENT, 6'd0, 7'd2},
        '{1'b0, 64'h0000_0000_0000_0000, 4'd8, 1'b0, ST_INSERTED, 6'd0, 7'd3},
        '{1'b0, 64'h0000_0000_0000_0000, 4'd1, 1'b0, ST_INSERTED, 6'd0, 7'd4},
        '{1'b0, 64'hAB00_0000_0000_0041, 4'd1, 1'b0, ST_INSERTED, 6'd0, 7'd5},
        '{1'b0, 64'h0000_0000_0000_0041, 4'd1, 1'b0, ST_PRESENT, 6'd0, 7'd5},
        '{1'b1, 64'h0000_0000_0000_0041, 4'd1, 1'b0, ST_REMOVED, 6'd0, 7'd4},
        '{1'b1, 64'h0000_0000_0000_0041, 4'd1, 1'b1, ST_NOTFOUND, 6'd0, 7'd4},
        '{1'b0, 64'h0000_0000_0000_0041, 4'd1, 1'b0, ST_INSERTED, 6'd0, 7'd5},
        '{1'b1, 64'h5555_5555_5555_5555, 4'd7, 1'b1, ST_NOTFOUND, 6'd0, 7'd5}
    };

    initial
    begin
        verdict_t v;
        request.valid = 1'b0;
        request.operation = 1'b0;
        request.key_bytes = '0;
        request.key_length = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_CAPACITY;
        cfg.data = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            set_mark[i] = MARK_EMPTY;
        end
        set_live = 0;
        set_capacity = CAP_RESET;
        set_limit = LIMIT_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            v.status = directed_rows[r].status;
            v.slot_index = directed_rows[r].slot_index;
            v.live_entries = directed_rows[r].live_entries;
            send_op(directed_rows[r].operation, directed_rows[r].key_bytes,
                    directed_rows[r].key_length, directed_rows[r].typed, v);
        end
        drain_results();

        write_register(CFG_LOAD_LIMIT, 7'd0);
        v = '{ST_FULL, 6'd0, 7'd5};
        send_op(1'b0, 64'h77, 4'd1, 1'b1, v);
        drain_results();
        write_register(CFG_CAPACITY, 7'd2);
        write_register(CFG_LOAD_LIMIT, 7'd100);
        random_phase(150, 16);
        drain_results();
        write_register(CFG_CAPACITY, 7'd0);
        write_register(CFG_LOAD_LIMIT, 7'd127);
        random_phase(150, 16);
        drain_results();
        write_register(CFG_CAPACITY, 7'd127);
        random_phase(400, 4096);
        drain_results();
        write_register(CFG_CAPACITY, 7'd64);
        write_register(CFG_LOAD_LIMIT, 7'd1);
        random_phase(100, 256);
        drain_results();
        write_register(CFG_CAPACITY, 7'd7);
        write_register(CFG_LOAD_LIMIT, 7'd100);
        random_phase(300, 32);
        drain_results();
        write_register(CFG_CAPACITY, 7'd61);
        write_register(CFG_LOAD_LIMIT, 7'd75);
        random_phase(800, 1024);
        drain_results();

        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule
